/* rtl/core/spq_pkg.sv */
// spq_pkg: shared constants and types for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing.
package spq_pkg;

   localparam int QUEUE_DEPTH    = 64;
   localparam int KEY_BITS       = 32;
   // keys arrive on a 32-bit port, so at most 32 bits are ever kept
   localparam int STORE_KEY_BITS = (KEY_BITS < 32) ? KEY_BITS : 32;
   localparam int CNT_BITS       = $clog2(QUEUE_DEPTH + 1);

   localparam logic FUNC_ENQUEUE = 1'b0;
   localparam logic FUNC_DEQUEUE = 1'b1;

   typedef struct packed {
      logic [STORE_KEY_BITS-1:0] key;
      logic [31:0]               handle;
      logic [15:0]               length;
   } entry_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE
   } op_type;

   // broadcast to every cell in the chain
   typedef struct packed {
      op_type    op;
      entry_type word;
   } cell_ctl_type;

   typedef struct packed {
      logic        success;
      logic [31:0] out_key;
      logic [31:0] out_handle;
      logic [15:0] out_length;
      logic [6:0]  occupancy;
   } result_type;

endpackage

/* rtl/core/spq_cell.sv */
// spq_cell: one slot of the sorted chain; holds one entry.
// Depends on spq_pkg.
module spq_cell
   import spq_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         occupied,
   input  logic         left_gt,
   input  entry_type    left_word,
   input  entry_type    right_word,
   output logic         gt,
   output entry_type    word
);

   entry_type word_ff, word_in;

   // this slot is empty or holds a strictly greater key than the new word
   assign gt   = !occupied || (word_ff.key > ctl.word.key);
   assign word = word_ff;

   always_comb begin
      word_in = word_ff;
      case (ctl.op)
         OP_INSERT: begin
            if (gt) begin
               word_in = left_gt ? left_word : ctl.word;
            end
         end
         OP_REMOVE: begin
            word_in = right_word;
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

/* rtl/core/sorted_priority_queue.sv */
// sorted_priority_queue: top level; chain of spq_cell slots plus a two-deep
// result buffer. Depends on spq_pkg and spq_cell.
//
// Usage:
//   req_ channel: one word per operation. req_func selects enqueue or
//   dequeue; key, handle and length are used only by enqueue.
//   rsp_ channel: exactly one result word per request, in request order.
//   Results are registered in rsp_ff, or in the spare word if rsp_ff is held.
//   Throughput: one operation per cycle while req_stall is low. All cells
//   update in parallel, each comparing its own key with the broadcast key,
//   so the compare in one cell sets the cycle time regardless of depth.
//   Stall: results go into a two-word buffer. A request is still taken while
//   one result waits; req_stall rises only when both buffer words are full.
//   Reset: clears the entry count and the result buffer valid flags. Slot
//   contents are not cleared; slots at or above the count never reach a result.
//   Full enqueue and empty dequeue return success 0; key, handle, length are 0.
module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [31:0] req_key,
   input  logic [31:0] req_payload_handle,
   input  logic [15:0] req_payload_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_success,
   output logic [31:0] rsp_out_key,
   output logic [31:0] rsp_out_handle,
   output logic [15:0] rsp_out_length,
   output logic [6:0]  rsp_occupancy
);

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                spare_valid_ff, spare_valid_in;
   result_type          rsp_ff, rsp_in;
   result_type          spare_ff, spare_in;

   logic                accept, take, is_full, is_empty;
   cell_ctl_type        ctl;
   result_type          result;
   logic      [QUEUE_DEPTH-1:0] gt;
   entry_type           words [QUEUE_DEPTH];

   assign accept   = req_valid && !req_stall;
   assign take     = rsp_valid_ff && !rsp_stall;
   assign is_full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   // control broadcast to the chain
   always_comb begin
      ctl.word.key    = req_key[STORE_KEY_BITS-1:0];
      ctl.word.handle = req_payload_handle;
      ctl.word.length = req_payload_length;
      ctl.op          = OP_HOLD;
      if (accept) begin
         if (req_func == FUNC_ENQUEUE && !is_full) begin
            ctl.op = OP_INSERT;
         end else if (req_func == FUNC_DEQUEUE && !is_empty) begin
            ctl.op = OP_REMOVE;
         end
      end
   end

   // the chain: cell 0 holds the lowest key
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic      left_gt;
      entry_type left_word, right_word;
      if (i == 0) begin : g_head
         assign left_gt   = 1'b0;
         assign left_word = ctl.word;
      end else begin : g_mid
         assign left_gt   = gt[i-1];
         assign left_word = words[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_word = words[i];
      end else begin : g_body
         assign right_word = words[i+1];
      end
      spq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (count_ff > CNT_BITS'(i)),
         .left_gt    (left_gt),
         .left_word  (left_word),
         .right_word (right_word),
         .gt         (gt[i]),
         .word       (words[i])
      );
   end

   // count and result word for the current request
   always_comb begin
      count_in = count_ff;
      result   = '0;
      case (ctl.op)
         OP_INSERT: begin
            count_in          = count_ff + 1'b1;
            result.success    = 1'b1;
            result.out_key    = 32'(ctl.word.key);
            result.out_handle = ctl.word.handle;
            result.out_length = ctl.word.length;
         end
         OP_REMOVE: begin
            count_in          = count_ff - 1'b1;
            result.success    = 1'b1;
            result.out_key    = 32'(words[0].key);
            result.out_handle = words[0].handle;
            result.out_length = words[0].length;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      result.occupancy = 7'(count_in);
   end

   // two-word result buffer; spare only fills when rsp is held
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      spare_valid_in = spare_valid_ff;
      rsp_in         = rsp_ff;
      spare_in       = spare_ff;
      if (spare_valid_ff) begin
         if (take) begin
            rsp_in         = spare_ff;
            spare_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || take) begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
         end else begin
            spare_in       = result;
            spare_valid_in = 1'b1;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff   <= rsp_in;
      spare_ff <= spare_in;
   end

   assign req_stall      = spare_valid_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_success    = rsp_ff.success;
   assign rsp_out_key    = rsp_ff.out_key;
   assign rsp_out_handle = rsp_ff.out_handle;
   assign rsp_out_length = rsp_ff.out_length;
   assign rsp_occupancy  = rsp_ff.occupancy;

   // count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("entry count above depth");

   // spare word is only ever held behind a waiting rsp word
   a_spare_order: assert property (@(posedge clock) disable iff (reset)
      spare_valid_ff |-> rsp_valid_ff)
      else $error("spare word without rsp word");

   // enqueue into non-full store grows the count by one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_ENQUEUE && !is_full)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow count");

   // head cell can be at or below the new key only when the chain is not empty
   a_chain_sorted: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_INSERT && !gt[0]) |-> !is_empty)
      else $error("empty chain reports a smaller head key");

endmodule
